// ===== rtl/u8d_pkg.sv =====
// Shared types and constants for the UTF-8 stream decoder.
package u8d_pkg;

  localparam int unsigned CP_W                = 21;
  localparam int unsigned BYTE_W              = 8;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [CP_W-1:0] BAD_RUNE_RESET = 21'h00FFFD;

  // Lead byte thresholds
  localparam logic [BYTE_W-1:0] LEAD_ASCII_END = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD_TWO       = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD_THREE     = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_FOUR      = 8'hF0;

  // Top two bits of a continuation byte
  localparam logic [1:0] CONT_TAG = 2'b10;

  typedef logic [CP_W-1:0] cp_t;

  // One decode command: nbad replacement results, then an optional tail result.
  typedef struct packed {
    logic [1:0] nbad;
    logic       has_tail;
    logic       tail_bad;
    cp_t        tail_cp;
  } cmd_t;

endpackage

// ===== rtl/u8d_front.sv =====
// Front end: byte acceptance, sequence tracking and command generation.
module u8d_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [u8d_pkg::BYTE_W-1:0] in_byte,
  input  logic                       q_full,
  output logic                       push,
  output u8d_pkg::cmd_t              cmd
);
  import u8d_pkg::*;

  typedef struct packed {
    logic       opens;
    logic [2:0] len;
    cp_t        acc;
    logic       tail;
    logic       bad;
    cp_t        cp;
  } lead_t;

  function automatic lead_t classify_lead(input logic [BYTE_W-1:0] b);
    lead_t r;
    r = '0;
    if (b < LEAD_ASCII_END) begin
      r.tail = 1'b1;
      r.cp   = {14'b0, b[6:0]};
    end else if (b < LEAD_TWO) begin
      r.tail = 1'b1;
      r.bad  = 1'b1;
    end else if (b >= LEAD_FOUR) begin
      r.opens = 1'b1;
      r.len   = 3'd4;
      r.acc   = {18'b0, b[2:0]};
    end else if (b >= LEAD_THREE) begin
      r.opens = 1'b1;
      r.len   = 3'd3;
      r.acc   = {17'b0, b[3:0]};
    end else begin
      r.opens = 1'b1;
      r.len   = 3'd2;
      r.acc   = {16'b0, b[4:0]};
    end
    return r;
  endfunction

  logic [2:0] expected_len, expected_len_next;
  logic [1:0] bytes_taken, bytes_taken_next;
  cp_t        accumulator, accumulator_next;

  lead_t      lead;
  logic       is_cont;
  logic       accept;
  cp_t        cont_acc;
  logic [1:0] cont_taken;
  logic       cont_done;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    lead       = classify_lead(in_byte);
    is_cont    = (in_byte[7:6] == CONT_TAG);
    cont_acc   = {accumulator[CP_W-7:0], in_byte[5:0]};
    cont_taken = bytes_taken + 2'd1;
    cont_done  = ({1'b0, cont_taken} >= expected_len) || (cont_taken == 2'd0);

    expected_len_next = expected_len;
    bytes_taken_next  = bytes_taken;
    accumulator_next  = accumulator;
    cmd               = '0;

    if (expected_len == 3'd0 || !is_cont) begin
      // Cut-off sequence: one replacement per byte already taken
      if (expected_len != 3'd0) begin
        cmd.nbad = bytes_taken;
      end
      cmd.has_tail = lead.tail;
      cmd.tail_bad = lead.bad;
      cmd.tail_cp  = lead.cp;
      if (lead.opens) begin
        expected_len_next = lead.len;
        bytes_taken_next  = 2'd1;
        accumulator_next  = lead.acc;
      end else begin
        expected_len_next = 3'd0;
        bytes_taken_next  = 2'd0;
        accumulator_next  = '0;
      end
    end else if (cont_done) begin
      cmd.has_tail      = 1'b1;
      cmd.tail_cp       = cont_acc;
      expected_len_next = 3'd0;
      bytes_taken_next  = 2'd0;
      accumulator_next  = '0;
    end else begin
      bytes_taken_next = cont_taken;
      accumulator_next = cont_acc;
    end

    push = accept && ((cmd.nbad != 2'd0) || cmd.has_tail);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_len <= 3'd0;
      bytes_taken  <= 2'd0;
      accumulator  <= '0;
    end else if (accept) begin
      expected_len <= expected_len_next;
      bytes_taken  <= bytes_taken_next;
      accumulator  <= accumulator_next;
    end
  end

endmodule

// ===== rtl/u8d_queue.sv =====
// Short command queue between the decoder front end and the result expander.
module u8d_queue #(
  parameter int unsigned DEPTH = u8d_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  u8d_pkg::cmd_t push_data,
  input  logic          pop,
  output u8d_pkg::cmd_t head,
  output logic          head_valid,
  output logic          full
);
  import u8d_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head       = entries[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/u8d_back.sv =====
// Back end: expands each command into result items through an output register.
module u8d_back (
  input  logic          clk,
  input  logic          rst,
  input  u8d_pkg::cp_t  bad_rune_value,
  input  u8d_pkg::cmd_t head,
  input  logic          head_valid,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output u8d_pkg::cp_t  code_point,
  output logic          is_bad,
  output logic          last
);
  import u8d_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       emit;
  logic       at_tail;
  logic       res_bad;
  logic       res_last;

  assign load = !out_valid || !out_stall;
  assign emit = load && head_valid;

  always_comb begin
    at_tail  = head.has_tail && (idx == head.nbad);
    res_bad  = !at_tail || head.tail_bad;
    res_last = at_tail || (!head.has_tail && (idx == head.nbad - 2'd1));
  end

  assign pop = emit && res_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= head_valid;
      end
      if (emit) begin
        idx <= res_last ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      code_point <= res_bad ? bad_rune_value : head.tail_cp;
      is_bad     <= res_bad;
      last       <= res_last;
    end
  end

endmodule

// ===== rtl/utf8_stream_decoder_top.sv =====
// Top level of the UTF-8 stream decoder: front end, command queue, result expander.
//
// Usage:
//   Input channel (in_valid / in_stall / in_byte) takes one raw byte per request.
//   Output channel (out_valid / out_stall / code_point, is_bad, last) gives
//   zero to four results per byte; last marks the final result of a byte.
//   Configuration channel (cfg_valid / cfg_ready / cfg_data) writes the
//   replacement code point; cfg_ready is always high. Write it only while idle.
// Timing:
//   A byte's first result passes the command queue and then the output register.
//   One byte per cycle is sustained while each byte yields at most one result;
//   a cut-off sequence costs one output cycle per replacement, and the
//   QUEUE_DEPTH-entry command queue absorbs such bursts before in_stall rises.
// Reset:
//   rst (synchronous) closes any open sequence, empties the queue, drops
//   out_valid and restores the replacement code point to U+FFFD.
// Stall:
//   While out_stall is high the output register holds; the queue fills and
//   then in_stall rises until the receiver takes results again.
module utf8_stream_decoder_top #(
  parameter int unsigned QUEUE_DEPTH = u8d_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [u8d_pkg::BYTE_W-1:0] in_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [u8d_pkg::CP_W-1:0]   code_point,
  output logic                       is_bad,
  output logic                       last,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [u8d_pkg::CP_W-1:0]   cfg_data
);
  import u8d_pkg::*;

  cp_t  bad_rune_value;
  cmd_t push_cmd;
  cmd_t head;
  logic push;
  logic pop;
  logic head_valid;
  logic q_full;

  // Configuration register: always ready, written on any request
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bad_rune_value <= BAD_RUNE_RESET;
    end else if (cfg_valid) begin
      bad_rune_value <= cfg_data;
    end
  end

  // Classify bytes and track the open sequence
  u8d_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .q_full   (q_full),
    .push     (push),
    .cmd      (push_cmd)
  );

  // Decouple the front end from the output side
  u8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_cmd),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (q_full)
  );

  // Expand commands into results, one per output cycle
  u8d_back u_back (
    .clk            (clk),
    .rst            (rst),
    .bad_rune_value (bad_rune_value),
    .head           (head),
    .head_valid     (head_valid),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .code_point     (code_point),
    .is_bad         (is_bad),
    .last           (last)
  );

endmodule

// ===== verif/utf8_stream_decoder_top_test.sv =====
// Self-checking testbench for the UTF-8 stream decoder top level.
module utf8_stream_decoder_top_test;
  import u8d_pkg::*;

  localparam int IDLE_PCT     = 24;    // chance in a hundred that a side idles
  localparam int DRAIN_CYCLES = 16;    // settle time once every result is in
  localparam int STALL_LIMIT  = 1000;  // cycles with no handshake before giving up
  localparam int PHASE_BYTES  = 52;    // random bytes per configuration phase

  // One decoded result as the receiver should see it.
  typedef struct packed {
    cp_t  cp;
    logic bad;
    logic fin;
  } rune_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] in_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  cp_t               code_point;
  logic              is_bad;
  logic              last;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  cp_t               cfg_data = '0;

  utf8_stream_decoder_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code_point (code_point),
    .is_bad     (is_bad),
    .last       (last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Byte stream still to be sent, and decoded results still to arrive.
  logic [BYTE_W-1:0] byte_q[$];
  rune_t             rune_q[$];

  bit calm = 1'b0;       // high while neither side idles
  bit byte_fire = 1'b0;  // a byte request was taken at the last rising edge
  int error_count = 0;
  int quiet_cycles = 0;

  // Decoder state mirrored on the testbench side.
  cp_t        bad_cp    = BAD_RUNE_RESET;
  logic [2:0] seq_len   = '0;  // length of the open sequence, zero when none
  logic [1:0] seq_count = '0;  // bytes of the open sequence taken, lead included
  cp_t        acc       = '0;  // value bits gathered so far

  // Results caused by the byte being decoded, at most four.
  rune_t step_res[4];
  int    step_n;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic void add_rune(input cp_t cp, input logic bad);
    step_res[step_n] = '{cp: cp, bad: bad, fin: 1'b0};
    step_n++;
  endfunction

  // Treat a byte as the start of a new character while no sequence is open.
  function automatic void start_lead(input logic [BYTE_W-1:0] b);
    if (b < LEAD_ASCII_END) begin
      add_rune(cp_t'(b[6:0]), 1'b0);
    end else if (b < LEAD_TWO) begin
      add_rune(bad_cp, 1'b1);
    end else begin
      if (b >= LEAD_FOUR) begin
        seq_len = 3'd4;
        acc = cp_t'(b[2:0]);
      end else if (b >= LEAD_THREE) begin
        seq_len = 3'd3;
        acc = cp_t'(b[3:0]);
      end else begin
        seq_len = 3'd2;
        acc = cp_t'(b[4:0]);
      end
      seq_count = 2'd1;
    end
  endfunction

  function automatic void close_sequence();
    seq_len = '0;
    seq_count = '0;
    acc = '0;
  endfunction

  // Advance the mirrored decoder by one byte and queue what it emits.
  function automatic void decode_byte(input logic [BYTE_W-1:0] b);
    int i;
    step_n = 0;
    if (seq_len == 3'd0) begin
      start_lead(b);
    end else if (b[7:6] == CONT_TAG) begin
      acc = {acc[CP_W-7:0], b[5:0]};
      seq_count = seq_count + 2'd1;
      // the two-bit count wraps to zero on the fourth byte of a long sequence
      if (seq_count == 2'd0 || {1'b0, seq_count} >= seq_len) begin
        add_rune(acc, 1'b0);
        close_sequence();
      end
    end else begin
      // cut off: one replacement per byte already taken, then restart on b
      for (i = 0; i < int'(seq_count); i++) add_rune(bad_cp, 1'b1);
      close_sequence();
      start_lead(b);
    end
    for (i = 0; i < step_n; i++) begin
      step_res[i].fin = (i == step_n - 1);
      rune_q.push_back(step_res[i]);
    end
  endfunction

  function automatic logic [BYTE_W-1:0] cont_byte();
    return {CONT_TAG, 6'($urandom_range(0, 63))};
  endfunction

  // Pick a lead for a sequence of the given length (2 to 4) with random value bits.
  function automatic logic [BYTE_W-1:0] lead_byte(input int len);
    case (len)
      2: return LEAD_TWO | BYTE_W'($urandom_range(0, 31));
      3: return LEAD_THREE | BYTE_W'($urandom_range(0, 15));
      default: return LEAD_FOUR | BYTE_W'($urandom_range(0, 15));
    endcase
  endfunction

  // Queue a mix of whole sequences, cut-off sequences and raw noise.
  task automatic queue_random_bytes(input int budget);
    int sent;
    int pick;
    int len;
    int k;
    int r;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        byte_q.push_back(BYTE_W'($urandom_range(0, 127)));
        sent++;
      end else if (pick < 65) begin
        len = (pick < 35) ? 2 : (pick < 50) ? 3 : 4;
        byte_q.push_back(lead_byte(len));
        for (k = 1; k < len; k++) byte_q.push_back(cont_byte());
        sent += len;
      end else if (pick < 82) begin
        // open a sequence, drop its tail, break it with a non-continuation byte
        len = $urandom_range(2, 4);
        byte_q.push_back(lead_byte(len));
        k = $urandom_range(0, len - 2);
        sent += k + 2;
        while (k > 0) begin
          byte_q.push_back(cont_byte());
          k--;
        end
        r = $urandom_range(0, 191);
        byte_q.push_back(BYTE_W'(r < 128 ? r : r + 64));
      end else begin
        byte_q.push_back(BYTE_W'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  // Write the replacement code point; the block is idle whenever this is called.
  task automatic write_bad_rune(input cp_t value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    bad_cp = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold until every byte is sent and every result is in, then let the block settle.
  task automatic wait_drained();
    while (byte_q.size() != 0 || in_valid || rune_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Driver: present a new byte only when the previous request was taken or none
  // was up; hold a stalled request unchanged. Idle choices ignore in_stall.
  always @(negedge clk) begin
    if (!rst && (!in_valid || byte_fire)) begin
      if (byte_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        in_byte  <= byte_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Monitor: check each taken result against the oldest expectation, then feed
  // each taken byte to the mirrored decoder. A byte's results come out only after
  // the command queue and output register, so this order never mixes up the two.
  always @(posedge clk) begin : monitor
    rune_t want;
    if (rst) begin
      byte_fire <= 1'b0;
    end else begin
      byte_fire <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (rune_q.size() == 0) begin
          report_mismatch("unexpected result", 32'(code_point), 32'hFFFF_FFFF);
        end else begin
          want = rune_q.pop_front();
          if (code_point !== want.cp) report_mismatch("code_point", 32'(code_point), 32'(want.cp));
          if (is_bad !== want.bad) report_mismatch("is_bad", 32'(is_bad), 32'(want.bad));
          if (last !== want.fin) report_mismatch("last", 32'(last), 32'(want.fin));
        end
      end
      if (in_valid && !in_stall) decode_byte(in_byte);
    end
  end

  // Watchdog: count cycles with no handshake on any channel and end the run
  // when the count reaches the limit.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("utf8_stream_decoder_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int ph;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed bytes under the reset replacement value: ASCII extremes, a stray
    // continuation, whole sequences of every length, and sequences cut off by NUL,
    // by ASCII and by a new lead (0xFF as a four-byte lead).
    byte_q = '{8'h00, 8'h7F, 8'h80, 8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC,
               8'hF0, 8'h9F, 8'h98, 8'h80, 8'hE0, 8'h80, 8'h00, 8'hF4,
               8'h41, 8'hFF, 8'h80, 8'h80, 8'hC3, 8'hA9};
    wait_drained();

    // Random phases, each under a different replacement value; the extremes
    // come first, and one phase runs with no idling on either side.
    for (ph = 1; ph <= 4; ph++) begin
      case (ph)
        1: write_bad_rune('0);
        2: write_bad_rune('1);
        3: write_bad_rune(cp_t'($urandom_range(0, 2097151)));
        default: write_bad_rune(BAD_RUNE_RESET);
      endcase
      calm = (ph == 3);
      queue_random_bytes(PHASE_BYTES);
      wait_drained();
    end

    if (error_count == 0) begin
      $display("utf8_stream_decoder_top test passed");
    end else begin
      $display("utf8_stream_decoder_top test failed");
    end
    $finish;
  end

endmodule
